/* src/srw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selective-repeat receive window package
// Shared widths, result kinds and the word types passed between the sequencer
// and the top level.
// ----------------------------------------------------------------------------
package srw_pkg;

  localparam int SEQ_W  = 31;
  localparam int SIZE_W = 11;
  localparam int TAG_W  = 8;

  localparam int WIN_SLOTS_DEF   = 8;
  localparam int MAX_PAYLOAD_DEF = 1024;

  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [SIZE_W-1:0] size;
    logic [TAG_W-1:0]  tag;
    logic              last_pkt;
  } pkt_t;

  typedef struct packed {
    logic              valid;
    logic              kind;
    logic [SEQ_W-1:0]  seq;
    logic [SIZE_W-1:0] size;
    logic [TAG_W-1:0]  tag;
    logic              xfer_end;
    logic              run_last;
  } word_t;

endpackage

/* src/srw_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selective-repeat receive window sequencer
// Holds the window base, the slot store and its filled bits, and steps one
// packet through placement, in-order release and acknowledgement using a
// single shared subtractor for the window and sequence compares.
// ----------------------------------------------------------------------------
module srw_ctrl #(
  parameter int WIN_SLOTS = srw_pkg::WIN_SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  srw_pkg::pkt_t pkt_in,
  output logic          busy,
  output srw_pkg::word_t word
);

  localparam int SLOT_W = $clog2(WIN_SLOTS);
  localparam int SEQ_W  = srw_pkg::SEQ_W;
  localparam logic [SLOT_W:0]   W_EXT   = (SLOT_W+1)'(WIN_SLOTS);
  localparam logic [SLOT_W-1:0] W_LAST  = SLOT_W'(WIN_SLOTS - 1);
  localparam logic [SEQ_W-1:0]  W_SEQ   = SEQ_W'(WIN_SLOTS);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CALC  = 6'b000010,
    ST_STORE = 6'b000100,
    ST_READ  = 6'b001000,
    ST_CHECK = 6'b010000,
    ST_ACK   = 6'b100000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [SEQ_W-1:0]       base_r, base_nxt;
  logic [SLOT_W-1:0]      bslot_r, bslot_nxt;
  logic                   done_r, done_nxt;
  logic [WIN_SLOTS-1:0]   filled_r, filled_nxt;
  srw_pkg::pkt_t          pkt_r;
  logic [SLOT_W-1:0]      slot_r;
  logic                   store_r;

  srw_pkg::pkt_t          mem_r [WIN_SLOTS];
  srw_pkg::pkt_t          rd_data_r;
  logic [SLOT_W-1:0]      rd_addr;
  logic                   wr_en;

  logic [SEQ_W-1:0]       sub_a;
  logic [SEQ_W:0]         diff;
  logic                   in_win;
  logic                   seq_eq;
  logic [SLOT_W:0]        slot_sum;
  logic [SLOT_W-1:0]      slot_calc;
  logic                   store_ok;
  logic [SEQ_W:0]         base_inc;
  logic [SLOT_W-1:0]      bslot_inc;
  logic                   release_ok;

  // The one subtractor serves the window test and the release compare.
  assign sub_a  = (state_r == ST_CHECK) ? rd_data_r.seq : pkt_r.seq;
  assign diff   = {1'b0, sub_a} - {1'b0, base_r};
  assign in_win = diff[SEQ_W-1:0] < W_SEQ;
  assign seq_eq = diff[SEQ_W-1:0] == '0;

  // Without a wrap the slot follows from the base slot plus the distance;
  // with a wrap the sequence number is below the window size already.
  assign slot_sum  = {1'b0, bslot_r} + {1'b0, diff[SLOT_W-1:0]};
  assign slot_calc = diff[SEQ_W] ? pkt_r.seq[SLOT_W-1:0] :
                     (slot_sum >= W_EXT) ? SLOT_W'(slot_sum - W_EXT) :
                     slot_sum[SLOT_W-1:0];
  assign store_ok  = in_win && !filled_r[slot_calc];

  assign base_inc  = {1'b0, base_r} + {{SEQ_W{1'b0}}, 1'b1};
  assign bslot_inc = base_inc[SEQ_W] ? '0 :
                     (bslot_r == W_LAST) ? '0 : bslot_r + 1'b1;
  assign release_ok = filled_r[bslot_r] && seq_eq;

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    base_nxt   = base_r;
    bslot_nxt  = bslot_r;
    done_nxt   = done_r;
    filled_nxt = filled_r;
    rd_addr    = bslot_r;
    wr_en      = 1'b0;
    word.valid    = 1'b0;
    word.kind     = srw_pkg::KIND_DELIVER;
    word.seq      = rd_data_r.seq;
    word.size     = rd_data_r.size;
    word.tag      = rd_data_r.tag;
    word.xfer_end = rd_data_r.last_pkt;
    word.run_last = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (go) begin
          state_nxt = done_r ? ST_ACK : ST_CALC;
        end
      end
      ST_CALC: begin
        state_nxt = ST_STORE;
      end
      ST_STORE: begin
        if (store_r) begin
          wr_en = 1'b1;
          filled_nxt[slot_r] = 1'b1;
        end
        state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (release_ok) begin
          word.valid = 1'b1;
          filled_nxt[bslot_r] = 1'b0;
          if (rd_data_r.last_pkt) begin
            done_nxt  = 1'b1;
            state_nxt = ST_ACK;
          end else begin
            base_nxt  = base_inc[SEQ_W-1:0];
            bslot_nxt = bslot_inc;
            rd_addr   = bslot_inc;
          end
        end else begin
          state_nxt = ST_ACK;
        end
      end
      ST_ACK: begin
        word.valid    = 1'b1;
        word.kind     = srw_pkg::KIND_ACK;
        word.seq      = pkt_r.seq;
        word.size     = '0;
        word.tag      = '0;
        word.xfer_end = 1'b0;
        word.run_last = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      base_r   <= '0;
      bslot_r  <= '0;
      done_r   <= 1'b0;
      filled_r <= '0;
    end else begin
      state_r  <= state_nxt;
      base_r   <= base_nxt;
      bslot_r  <= bslot_nxt;
      done_r   <= done_nxt;
      filled_r <= filled_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go && (state_r == ST_IDLE)) begin
      pkt_r <= pkt_in;
    end
    if (state_r == ST_CALC) begin
      slot_r  <= slot_calc;
      store_r <= store_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[slot_r] <= pkt_r;
    end
    rd_data_r <= mem_r[rd_addr];
  end

endmodule

/* src/selective_repeat_receive_window_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selective-repeat receive window unit
// Places arriving packets in the receive window, releases filled slots in
// order from the window base and acknowledges every packet.
//
// Channel   Ports                          Handshake
// input     in_seq_number .. in_final_packet  start, busy
// result    out_kind .. out_run_last       out_valid strobe, one cycle
//
// A packet holds busy high in calc, store, read, a check per delivered packet,
// another check if the release run stops on an empty or stale slot, and ack;
// once the transfer is done busy is high for a single cycle. The release loop
// reads one slot a cycle from the single read port of the slot store.
// Reset is synchronous and active low and clears the window at once.
// Results cannot be held off: each stands on the outputs for one cycle.
// ----------------------------------------------------------------------------
module selective_repeat_receive_window_unit #(
  parameter int WIN_SLOTS   = srw_pkg::WIN_SLOTS_DEF,
  parameter int MAX_PAYLOAD = srw_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [srw_pkg::SEQ_W-1:0]   in_seq_number,
  input  logic [srw_pkg::SIZE_W-1:0]  in_payload_size,
  input  logic [srw_pkg::TAG_W-1:0]   in_payload_tag,
  input  logic                        in_final_packet,
  output logic                        out_valid,
  output logic                        out_kind,
  output logic [srw_pkg::SEQ_W-1:0]   out_seq,
  output logic [srw_pkg::SIZE_W-1:0]  out_size,
  output logic [srw_pkg::TAG_W-1:0]   out_tag,
  output logic                        out_transfer_end,
  output logic                        out_run_last
);

  localparam int SIZE_W = srw_pkg::SIZE_W;

  logic           go;
  srw_pkg::pkt_t  pkt_in;
  srw_pkg::word_t word;
  logic           valid_r;
  srw_pkg::word_t word_r;

  assign go = start && !busy;

  always_comb begin
    pkt_in.seq      = in_seq_number;
    pkt_in.tag      = in_payload_tag;
    pkt_in.last_pkt = in_final_packet;
    if (32'(in_payload_size) > 32'(MAX_PAYLOAD)) begin
      pkt_in.size = SIZE_W'(MAX_PAYLOAD);
    end else begin
      pkt_in.size = in_payload_size;
    end
  end

  srw_ctrl #(
    .WIN_SLOTS (WIN_SLOTS)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (go),
    .pkt_in (pkt_in),
    .busy   (busy),
    .word   (word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= word.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (word.valid) begin
      word_r <= word;
    end
  end

  assign out_valid        = valid_r;
  assign out_kind         = word_r.kind;
  assign out_seq          = word_r.seq;
  assign out_size         = word_r.size;
  assign out_tag          = word_r.tag;
  assign out_transfer_end = word_r.xfer_end;
  assign out_run_last     = word_r.run_last;

endmodule

/* bench/tb_selective_repeat_receive_window_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the selective-repeat receive window unit
// Sends packets through the start/busy handshake and checks every delivery and
// acknowledgement word against a window predictor kept in step with the block.
// A short directed part covers the window edges, duplicates, stale packets,
// oversized payloads and a full release run. Shuffled blocks of in-window
// packets with random noise follow, and the run closes with the final packet
// of the transfer and a few packets after it.
// ----------------------------------------------------------------------------
module tb_selective_repeat_receive_window_unit;

  localparam int SEQ_W       = srw_pkg::SEQ_W;
  localparam int SIZE_W      = srw_pkg::SIZE_W;
  localparam int TAG_W       = srw_pkg::TAG_W;
  localparam int WIN         = srw_pkg::WIN_SLOTS_DEF;
  localparam int MAXP        = srw_pkg::MAX_PAYLOAD_DEF;
  localparam int RANDOM_PKTS = 80;
  localparam int CALM_TAIL   = 20;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    srw_pkg::pkt_t pkt;
    bit            drain_first;
  } send_item_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [SEQ_W-1:0]  in_seq_number = '0;
  logic [SIZE_W-1:0] in_payload_size = '0;
  logic [TAG_W-1:0]  in_payload_tag = '0;
  logic              in_final_packet = 1'b0;
  logic              out_valid;
  logic              out_kind;
  logic [SEQ_W-1:0]  out_seq;
  logic [SIZE_W-1:0] out_size;
  logic [TAG_W-1:0]  out_tag;
  logic              out_transfer_end;
  logic              out_run_last;

  send_item_t     pending_packets[$];
  srw_pkg::word_t expected_words[$];

  logic             acc_valid = 1'b0;
  srw_pkg::pkt_t    acc_pkt = '0;
  logic             window_quiet = 1'b1;
  int               gap = 0;
  int               stall_cycles = 0;
  int               mismatches = 0;
  int               packets_sent = 0;
  int               words_checked = 0;
  int               deliveries_seen = 0;
  bit               end_seen = 1'b0;

  logic [SEQ_W-1:0]  win_base = '0;
  logic              win_done = 1'b0;
  logic              slot_full [WIN];
  logic [SEQ_W-1:0]  slot_seq  [WIN];
  logic [SIZE_W-1:0] slot_size [WIN];
  logic [TAG_W-1:0]  slot_tag  [WIN];
  logic              slot_fin  [WIN];

  selective_repeat_receive_window_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_seq_number    (in_seq_number),
    .in_payload_size  (in_payload_size),
    .in_payload_tag   (in_payload_tag),
    .in_final_packet  (in_final_packet),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_seq          (out_seq),
    .out_size         (out_size),
    .out_tag          (out_tag),
    .out_transfer_end (out_transfer_end),
    .out_run_last     (out_run_last)
  );

  always #1 clk = ~clk;

  function automatic void window_predict(input srw_pkg::pkt_t p);
    logic [SEQ_W-1:0]  seq_dist;
    logic [SIZE_W-1:0] sz;
    int                s;
    int                b;
    srw_pkg::word_t    w;
    sz = (p.size > MAXP) ? SIZE_W'(MAXP) : p.size;
    if (!win_done) begin
      seq_dist = p.seq - win_base;
      if (seq_dist < WIN) begin
        s = int'(p.seq % WIN);
        if (!slot_full[s]) begin
          slot_full[s] = 1'b1;
          slot_seq[s]  = p.seq;
          slot_size[s] = sz;
          slot_tag[s]  = p.tag;
          slot_fin[s]  = p.last_pkt;
        end
      end
      for (int i = 0; i < WIN; i++) begin
        b = int'(win_base % WIN);
        if (!slot_full[b] || slot_seq[b] != win_base) break;
        w          = '0;
        w.kind     = srw_pkg::KIND_DELIVER;
        w.seq      = slot_seq[b];
        w.size     = slot_size[b];
        w.tag      = slot_tag[b];
        w.xfer_end = slot_fin[b];
        expected_words.push_back(w);
        slot_full[b] = 1'b0;
        if (slot_fin[b]) begin
          win_done = 1'b1;
          break;
        end
        win_base = win_base + 1'b1;
      end
    end
    w          = '0;
    w.kind     = srw_pkg::KIND_ACK;
    w.seq      = p.seq;
    w.run_last = 1'b1;
    expected_words.push_back(w);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    if ($urandom_range(0, 3) == 0) return SIZE_W'($urandom_range(MAXP + 1, 2047));
    return SIZE_W'($urandom_range(0, MAXP));
  endfunction

  task automatic add_pkt(input logic [SEQ_W-1:0] seq, input logic [SIZE_W-1:0] size,
                         input logic [TAG_W-1:0] tag, input logic fin, input bit drain);
    send_item_t it;
    it.pkt.seq      = seq;
    it.pkt.size     = size;
    it.pkt.tag      = tag;
    it.pkt.last_pkt = fin;
    it.drain_first  = drain;
    pending_packets.push_back(it);
  endtask

  always @(posedge clk) begin
    send_item_t nxt;
    logic       take;
    logic       start_n;
    int         gap_n;
    if (!rst_n) begin
      start     <= 1'b0;
      acc_valid <= 1'b0;
      gap       <= 0;
    end else begin
      take    = start && !busy;
      start_n = 1'b0;
      gap_n   = gap;
      if (take) begin
        packets_sent++;
        acc_pkt <= '{seq: in_seq_number, size: in_payload_size, tag: in_payload_tag,
                     last_pkt: in_final_packet};
        if (pending_packets.size() > CALM_TAIL && $urandom_range(0, 2) == 0)
          gap_n = $urandom_range(1, 14);
      end
      if (start && !take) begin
        start_n = 1'b1;
      end else if (gap_n > 0) begin
        gap_n--;
      end else if (pending_packets.size() != 0 &&
                   !(pending_packets[0].drain_first && (take || acc_valid || !window_quiet))) begin
        nxt = pending_packets.pop_front();
        in_seq_number   <= nxt.pkt.seq;
        in_payload_size <= nxt.pkt.size;
        in_payload_tag  <= nxt.pkt.tag;
        in_final_packet <= nxt.pkt.last_pkt;
        start_n = 1'b1;
      end
      start     <= start_n;
      gap       <= gap_n;
      acc_valid <= take;
    end
  end

  always @(posedge clk) begin
    srw_pkg::word_t w;
    if (rst_n) begin
      if (acc_valid) window_predict(acc_pkt);
      if (out_valid) begin
        words_checked++;
        if (out_kind == srw_pkg::KIND_DELIVER) deliveries_seen++;
        if (out_kind == srw_pkg::KIND_DELIVER && out_transfer_end) end_seen = 1'b1;
        if (expected_words.size() == 0) begin
          $error("unexpected word: kind %0d, seq %0d", out_kind, out_seq);
          mismatches++;
        end else begin
          w = expected_words.pop_front();
          check_field("kind", w.kind, out_kind);
          check_field("out_seq", w.seq, out_seq);
          check_field("out_size", w.size, out_size);
          check_field("out_tag", w.tag, out_tag);
          check_field("transfer_end", w.xfer_end, out_transfer_end);
          check_field("run_last", w.run_last, out_run_last);
        end
      end
      window_quiet <= (expected_words.size() == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [SEQ_W-1:0] gb;
    logic [SEQ_W-1:0] s;
    int               order [WIN];
    int               n;
    int               j;
    int               t;
    int               made;
    bit               first;

    for (int i = 0; i < WIN; i++) slot_full[i] = 1'b0;

    // Directed part: window edges, stale and duplicate packets, clamping and a
    // release run of a whole window.
    add_pkt(0, 0, 0, 1'b0, 1'b0);
    add_pkt({SEQ_W{1'b1}}, 2047, 255, 1'b1, 1'b0);
    add_pkt(2, 1025, 8'hAA, 1'b0, 1'b0);
    add_pkt(9, 17, 8'h0F, 1'b1, 1'b0);
    add_pkt(8, MAXP, 8'h55, 1'b0, 1'b0);
    add_pkt(2, 5, 8'h01, 1'b1, 1'b0);
    add_pkt(1, 1023, 8'hF0, 1'b0, 1'b0);
    add_pkt(0, 300, 8'h33, 1'b1, 1'b0);
    add_pkt(4, 1, 8'h04, 1'b0, 1'b0);
    add_pkt(5, 512, 8'h05, 1'b0, 1'b0);
    add_pkt(6, 1536, 8'h06, 1'b0, 1'b0);
    add_pkt(7, 64, 8'h07, 1'b0, 1'b0);
    add_pkt(9, 999, 8'h09, 1'b0, 1'b0);
    add_pkt(10, 2, 8'h0A, 1'b0, 1'b0);
    add_pkt(3, 700, 8'h80, 1'b0, 1'b0);
    gb = 11;

    made  = 0;
    first = 1'b1;
    while (made < RANDOM_PKTS) begin
      n = ($urandom_range(0, 3) == 0) ? WIN : $urandom_range(1, WIN);
      for (int i = 0; i < n; i++) order[i] = i;
      for (int i = n - 1; i > 0; i--) begin
        j        = $urandom_range(0, i);
        t        = order[i];
        order[i] = order[j];
        order[j] = t;
      end
      for (int k = 0; k < n; k++) begin
        add_pkt(gb + SEQ_W'(order[k]), pick_size(), TAG_W'($urandom), 1'b0,
                first || (k == 0 && $urandom_range(0, 9) == 0));
        first = 1'b0;
        made++;
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 3))
            0: s = gb + SEQ_W'(order[$urandom_range(0, k)]);
            1: s = gb - SEQ_W'($urandom_range(1, 40));
            2: s = gb + SEQ_W'($urandom_range(2 * WIN, 5000));
            default: s = SEQ_W'($urandom);
          endcase
          add_pkt(s, pick_size(), TAG_W'($urandom),
                  ((s - gb) < 2 * WIN && s - gb >= n) ? 1'b0 : 1'($urandom), 1'b0);
          made++;
        end
      end
      gb = gb + SEQ_W'(n);
    end

    // Closing transfer: the highest packet of the last block is the final one,
    // and everything sent afterwards may only be acknowledged.
    n = $urandom_range(2, WIN);
    for (int i = 0; i < n; i++) order[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int k = 0; k < n; k++)
      add_pkt(gb + SEQ_W'(order[k]), pick_size(), TAG_W'($urandom),
              order[k] == n - 1, k == 0);
    add_pkt(gb + SEQ_W'(n), pick_size(), TAG_W'($urandom), 1'b0, 1'b1);
    add_pkt(gb + SEQ_W'(n - 1), pick_size(), TAG_W'($urandom), 1'b1, 1'b0);
    add_pkt(SEQ_W'($urandom), pick_size(), TAG_W'($urandom), 1'b1, 1'b0);
    add_pkt(gb + SEQ_W'(n + 1), pick_size(), TAG_W'($urandom), 1'b1, 1'b0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (pending_packets.size() != 0 || start || acc_valid || expected_words.size() != 0)
      @(negedge clk);
    repeat (32) @(posedge clk);

    if (expected_words.size() != 0) $error("%0d words never arrived", expected_words.size());
    $display("Sent %0d packets and checked %0d words, %0d of them in-order deliveries.",
             packets_sent, words_checked, deliveries_seen);
    $display("The end of the transfer was %0s.", end_seen ? "reached" : "not reached");
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
src/srw_pkg.sv
src/srw_ctrl.sv
src/selective_repeat_receive_window_unit.sv
bench/tb_selective_repeat_receive_window_unit.sv
